// File: rtl/card_number_luhn_classifier_assert.svh
// assertion macros shared by the card number classifier rtl
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CNLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("card classifier check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CNLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("card classifier check failed");

`endif

// File: rtl/cnlc_pkg.sv
// types, constants and helper functions of the card number classifier
package cnlc_pkg;

  // binary input and decimal conversion
  localparam int BIN_W      = 54;
  localparam int DIGIT_W    = 4;
  localparam int DEC_DIGITS = 17;
  localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
  localparam int STAGE_BITS = 6;
  localparam int NUM_DABBLE = BIN_W / STAGE_BITS;

  // luhn sum over the lowest digits
  localparam int MAX_DIGITS  = 16;
  localparam int LUHN_DIGITS = (MAX_DIGITS < DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;
  localparam int NUM_PAIRS   = (LUHN_DIGITS + 1) / 2;
  localparam int PAD_W       = NUM_PAIRS * 2 * DIGIT_W;
  localparam int PAIR_W      = 5;
  localparam int MAX_SUM     = NUM_PAIRS * 18;
  localparam int SUM_W       = $clog2(MAX_SUM + 1);
  localparam int CNT_W       = 5;

  // length and prefix rules
  localparam logic [CNT_W-1:0]   LEN_MIN   = CNT_W'(13);
  localparam logic [CNT_W-1:0]   LEN_MAX   = CNT_W'(16);
  localparam logic [CNT_W-1:0]   LEN_3X    = CNT_W'(15);
  localparam logic [CNT_W-1:0]   LEN_5X    = CNT_W'(16);
  localparam logic [DIGIT_W-1:0] LEAD_3    = 4'd3;
  localparam logic [DIGIT_W-1:0] SEC_4     = 4'd4;
  localparam logic [DIGIT_W-1:0] SEC_7     = 4'd7;
  localparam logic [DIGIT_W-1:0] LEAD_4    = 4'd4;
  localparam logic [DIGIT_W-1:0] LEAD_5    = 4'd5;
  localparam logic [DIGIT_W-1:0] SEC_5X_LO = 4'd1;
  localparam logic [DIGIT_W-1:0] SEC_5X_HI = 4'd5;

  typedef enum logic [1:0] {
    CLASS_INVALID      = 2'd0,
    CLASS_PREFIX_34_37 = 2'd1,
    CLASS_LEAD_4       = 2'd2,
    CLASS_PREFIX_51_55 = 2'd3
  } card_class_e;

  // result of the digit scan stage
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic [DIGIT_W-1:0]                lead;
    logic [DIGIT_W-1:0]                second;
    logic [NUM_PAIRS-1:0][PAIR_W-1:0]  pair_sum;
  } scan_t;

  // doubled digit with its two digits added
  function automatic logic [DIGIT_W-1:0] luhn_double(logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    return t[DIGIT_W-1:0];
  endfunction

  // true when the luhn sum is a multiple of ten
  function automatic logic is_mult10(logic [SUM_W-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= MAX_SUM / 10; k++) begin
      if (s == SUM_W'(k * 10)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: rtl/cnlc_if.sv
// handshake interfaces for card numbers in and classification results out
interface cnlc_in_if import cnlc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

interface cnlc_out_if import cnlc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       card_class;
  logic [CNT_W-1:0] digit_count;
  logic             checksum_ok;

  modport source (output valid, output card_class, output digit_count, output checksum_ok,
                  input ready);
  modport sink   (input valid, input card_class, input digit_count, input checksum_ok,
                  output ready);
endinterface

// File: rtl/card_number_luhn_classifier.sv
// Card number classifier: binary to decimal, length and prefix class, Luhn check.
// Pipeline: an accepted card number passes through nine conversion stages of six bits
// each, one digit scan stage and one result stage, each of them registered.
// Throughput: one card number per cycle; each stage holds under back-pressure and
// empty stages still take new transactions.
// Reset: rst_ni clears every stage's valid bit asynchronously; data is not reset.
`include "card_number_luhn_classifier_assert.svh"

module card_number_luhn_classifier import cnlc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  cnlc_in_if.sink            in_if,
  cnlc_out_if.source         out_if
);

  logic             dab_valid [NUM_DABBLE+1];
  logic             dab_ready [NUM_DABBLE+1];
  logic [BIN_W-1:0] dab_bin   [NUM_DABBLE+1];
  logic [BCD_W-1:0] dab_bcd   [NUM_DABBLE+1];
  logic             scan_valid;
  logic             scan_ready;
  scan_t            scan;

  // conversion chain entry
  assign dab_valid[0] = in_if.valid;
  assign dab_bin[0]   = in_if.card_number;
  assign dab_bcd[0]   = '0;
  assign in_if.ready  = dab_ready[0];

  // binary to bcd pipeline
  for (genvar k = 0; k < NUM_DABBLE; k++) begin : g_dabble
    cnlc_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dab_valid[k]),
      .ready_o (dab_ready[k]),
      .bin_i   (dab_bin[k]),
      .bcd_i   (dab_bcd[k]),
      .valid_o (dab_valid[k+1]),
      .ready_i (dab_ready[k+1]),
      .bin_o   (dab_bin[k+1]),
      .bcd_o   (dab_bcd[k+1])
    );
  end

  // digit scan
  cnlc_digit_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dab_valid[NUM_DABBLE]),
    .ready_o (dab_ready[NUM_DABBLE]),
    .bcd_i   (dab_bcd[NUM_DABBLE]),
    .valid_o (scan_valid),
    .ready_i (scan_ready),
    .scan_o  (scan)
  );

  // checksum, classification and output register
  cnlc_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (scan_valid),
    .ready_o       (scan_ready),
    .scan_i        (scan),
    .valid_o       (out_if.valid),
    .ready_i       (out_if.ready),
    .card_class_o  (out_if.card_class),
    .digit_count_o (out_if.digit_count),
    .checksum_ok_o (out_if.checksum_ok)
  );

  // an accepted card number occupies the first stage on the next cycle
  `CNLC_ASSERT_NEXT(a_accept_fills_first, in_if.valid && in_if.ready, dab_valid[1])
  // a reported class implies a passing checksum
  `CNLC_ASSERT_NOW(a_class_needs_ok, out_if.valid && out_if.card_class != CLASS_INVALID, out_if.checksum_ok)
  // a reported class implies a length between 13 and 16 digits
  `CNLC_ASSERT_NOW(a_class_len, out_if.valid && out_if.card_class != CLASS_INVALID, out_if.digit_count >= LEN_MIN && out_if.digit_count <= LEN_MAX)
  // the 34/37 class only ever comes with fifteen digits
  `CNLC_ASSERT_NOW(a_class_3x_len, out_if.valid && out_if.card_class == CLASS_PREFIX_34_37, out_if.digit_count == LEN_3X)

endmodule

// File: rtl/cnlc_dabble_stage.sv
// one pipeline stage of the binary to bcd conversion, six bits per stage
module cnlc_dabble_stage import cnlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [BIN_W-1:0] bin_i,
  input  logic [BCD_W-1:0] bcd_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [BIN_W-1:0] bin_o,
  output logic [BCD_W-1:0] bcd_o
);

  logic             valid_q;
  logic [BIN_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;

  // stage moves when empty or when the next stage takes its transaction
  assign ready_o = !valid_q || ready_i;

  // shift-and-add-three over this stage's share of input bits
  always_comb begin
    bin_d = bin_i;
    bcd_d = bcd_i;
    for (int b = 0; b < STAGE_BITS; b++) begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
        if (bcd_d[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_d[k*DIGIT_W +: DIGIT_W] = bcd_d[k*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[BIN_W-1]};
      bin_d = {bin_d[BIN_W-2:0], 1'b0};
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;

endmodule

// File: rtl/cnlc_digit_scan.sv
// digit count, leading digits and paired luhn terms from the bcd digits
module cnlc_digit_scan import cnlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [BCD_W-1:0] bcd_i,
  output logic             valid_o,
  input  logic             ready_i,
  output scan_t            scan_o
);

  logic             valid_q;
  scan_t            scan_q, scan_d;
  logic [PAD_W-1:0] padded;

  assign ready_o = !valid_q || ready_i;
  assign padded  = PAD_W'(bcd_i);

  // highest non-zero digit sets the count, then pick the two leading digits
  always_comb begin
    scan_d = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_i[i*DIGIT_W +: DIGIT_W] != '0) begin
        scan_d.count = CNT_W'(i + 1);
      end
    end
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (scan_d.count == CNT_W'(i + 1)) begin
        scan_d.lead   = bcd_i[i*DIGIT_W +: DIGIT_W];
        scan_d.second = bcd_i[(i-1)*DIGIT_W +: DIGIT_W];
      end
    end
    // each pair: plain digit plus the doubled digit above it
    for (int j = 0; j < NUM_PAIRS; j++) begin
      scan_d.pair_sum[j] = PAIR_W'(padded[2*j*DIGIT_W +: DIGIT_W]);
      if (2 * j + 1 < LUHN_DIGITS) begin
        scan_d.pair_sum[j] = scan_d.pair_sum[j]
                           + PAIR_W'(luhn_double(padded[(2*j+1)*DIGIT_W +: DIGIT_W]));
      end
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      scan_q <= scan_d;
    end
  end

  assign valid_o = valid_q;
  assign scan_o  = scan_q;

endmodule

// File: rtl/cnlc_classify.sv
// luhn total, mod-10 test and prefix classification into the output register
module cnlc_classify import cnlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  scan_t            scan_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [1:0]       card_class_o,
  output logic [CNT_W-1:0] digit_count_o,
  output logic             checksum_ok_o
);

  logic             valid_q;
  card_class_e      class_q, class_d;
  logic [CNT_W-1:0] count_q;
  logic             ok_q, ok_d;
  logic [SUM_W-1:0] sum;
  logic             len_ok;

  assign ready_o = !valid_q || ready_i;

  // total of the pair terms and the checksum test
  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_PAIRS; j++) begin
      sum = sum + SUM_W'(scan_i.pair_sum[j]);
    end
    ok_d = is_mult10(sum);
  end

  assign len_ok = (scan_i.count >= LEN_MIN) && (scan_i.count <= LEN_MAX);

  // prefix rules, cleared by a failed checksum
  always_comb begin
    class_d = CLASS_INVALID;
    if (len_ok) begin
      if (scan_i.count == LEN_3X && scan_i.lead == LEAD_3 &&
          (scan_i.second == SEC_4 || scan_i.second == SEC_7)) begin
        class_d = CLASS_PREFIX_34_37;
      end else if (scan_i.lead == LEAD_4) begin
        class_d = CLASS_LEAD_4;
      end else if (scan_i.count == LEN_5X && scan_i.lead == LEAD_5 &&
                   scan_i.second inside {[SEC_5X_LO:SEC_5X_HI]}) begin
        class_d = CLASS_PREFIX_51_55;
      end
    end
    if (!ok_d) begin
      class_d = CLASS_INVALID;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      class_q <= class_d;
      count_q <= scan_i.count;
      ok_q    <= ok_d;
    end
  end

  assign valid_o       = valid_q;
  assign card_class_o  = class_q;
  assign digit_count_o = count_q;
  assign checksum_ok_o = ok_q;

endmodule

// File: test/card_number_luhn_classifier_tb.sv
// self-checking testbench for the card number classifier: length, prefix class and luhn check
module card_number_luhn_classifier_tb;
  import cnlc_pkg::*;

  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 30;
  localparam int          PHASE_ITEMS    = 345;
  localparam int          MISMATCH_SHOWN = 10;
  localparam logic [63:0] TEN_POW_16     = 64'd10000000000000000;
  localparam logic [63:0] INPUT_SPAN     = 64'd1 << BIN_W;

  logic clk_i;
  logic rst_ni;

  cnlc_in_if  in_if ();
  cnlc_out_if out_if ();

  card_number_luhn_classifier DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // predicted outcome for one card number
  typedef struct {
    logic [BIN_W-1:0] card;
    card_class_e      cls;
    logic [CNT_W-1:0] count;
    logic             ok;
  } verdict_t;

  // luhn digit sum over the lowest MAX_DIGITS decimal digits
  function automatic int luhn_total(logic [63:0] num);
    int          s;
    int          dv;
    logic [63:0] rest;
    s    = 0;
    rest = num;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dv   = int'(rest % 64'd10);
      rest = rest / 64'd10;
      if (i % 2 == 1) begin
        dv = dv * 2;
        if (dv > 9) begin
          dv = dv - 9;
        end
      end
      s = s + dv;
    end
    return s;
  endfunction

  class card_scoreboard;
    verdict_t    pending_verdicts[$];
    int          errors;
    int          mismatches;
    int          checked;
    int          class_hits[4];
    logic [17:0] counts_seen;

    function new();
      errors      = 0;
      mismatches  = 0;
      checked     = 0;
      counts_seen = '0;
      foreach (class_hits[k]) begin
        class_hits[k] = 0;
      end
    endfunction

    // split into decimal digits, measure length, classify prefix, apply luhn
    function verdict_t classify_card(logic [BIN_W-1:0] card);
      verdict_t    v;
      logic [63:0] rest;
      int          digs[DEC_DIGITS];
      int          len;
      int          lead2;
      rest = 64'(card);
      len  = 0;
      for (int i = 0; i < DEC_DIGITS; i++) begin
        digs[i] = int'(rest % 64'd10);
        rest    = rest / 64'd10;
        if (digs[i] != 0 || rest != 0) begin
          len = i + 1;
        end
      end
      v.card  = card;
      v.count = CNT_W'(len);
      v.ok    = (luhn_total(64'(card)) % 10) == 0;
      v.cls   = CLASS_INVALID;
      if (len >= 13 && len <= 16) begin
        lead2 = digs[len-1] * 10 + digs[len-2];
        if (len == 15 && (lead2 == 34 || lead2 == 37)) begin
          v.cls = CLASS_PREFIX_34_37;
        end else if (digs[len-1] == 4) begin
          v.cls = CLASS_LEAD_4;
        end else if (len == 16 && lead2 >= 51 && lead2 <= 55) begin
          v.cls = CLASS_PREFIX_51_55;
        end
      end
      if (!v.ok) begin
        v.cls = CLASS_INVALID;
      end
      return v;
    endfunction

    function void note_card(logic [BIN_W-1:0] card);
      pending_verdicts.push_back(classify_card(card));
    endfunction

    function void check_verdict(logic [1:0] cls, logic [CNT_W-1:0] count, logic ok);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN) begin
          $display("unexpected result: class %0d count %0d checksum %0b", cls, count, ok);
        end
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      class_hits[want.cls]++;
      counts_seen[want.count] = 1'b1;
      if (cls !== want.cls || count !== want.count || ok !== want.ok) begin
        errors++;
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN) begin
          $display({"mismatch for card %0d: expected class %0d count %0d checksum %0b, ",
                    "got %0d %0d %0b"},
                   want.card, want.cls, want.count, want.ok, cls, count, ok);
        end
      end
    endfunction
  endclass

  card_scoreboard book = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int quiet_cycles;

  // card number of a given length and leading digits, check digit optionally fixed up
  function automatic logic [BIN_W-1:0] build_card(int len, int prefix, int plen, bit fix);
    logic [63:0] acc;
    int          d;
    acc = '0;
    if (len > 16) begin
      acc = TEN_POW_16 + ({$urandom, $urandom} % (INPUT_SPAN - TEN_POW_16));
    end else begin
      for (int i = 0; i < len; i++) begin
        if (plen == 2 && i == 0) begin
          d = prefix / 10;
        end else if (plen == 2 && i == 1) begin
          d = prefix % 10;
        end else if (plen == 1 && i == 0) begin
          d = prefix;
        end else if (i == 0) begin
          d = $urandom_range(9, 1);
        end else begin
          d = $urandom_range(9, 0);
        end
        acc = acc * 64'd10 + 64'(d);
      end
      if (fix && len > 0) begin
        acc = acc - acc % 64'd10;
        acc = acc + 64'((10 - luhn_total(acc) % 10) % 10);
      end
    end
    return acc[BIN_W-1:0];
  endfunction

  // replace the check digit by a different one so the luhn test fails
  function automatic logic [BIN_W-1:0] spoil_check_digit(logic [BIN_W-1:0] card);
    logic [63:0] acc;
    logic [63:0] d;
    acc = 64'(card);
    d   = acc % 64'd10;
    acc = acc - d + (d + 64'($urandom_range(9, 1))) % 64'd10;
    return acc[BIN_W-1:0];
  endfunction

  // mostly well-formed cards with random digits, plus broken and raw numbers
  function automatic logic [BIN_W-1:0] random_card();
    logic [BIN_W-1:0] card;
    int               r;
    r = $urandom_range(99);
    case ($urandom_range(2))
      0:       card = build_card(15, $urandom_range(1) ? 34 : 37, 2, 1'b1);
      1:       card = build_card($urandom_range(16, 13), 4, 1, 1'b1);
      default: card = build_card(16, $urandom_range(55, 51), 2, 1'b1);
    endcase
    if (r < 55) begin
      return card;
    end else if (r < 70) begin
      return spoil_check_digit(card);
    end else if (r < 82) begin
      return build_card($urandom_range(17, 11), $urandom_range(99, 10), 2, 1'b1);
    end
    card = BIN_W'({$urandom, $urandom});
    if ($urandom_range(1)) begin
      card = card >> $urandom_range(BIN_W - 1);
    end
    return card;
  endfunction

  // offer one card number and wait for the transaction
  task automatic send_card(input logic [BIN_W-1:0] card);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.card_number <= card;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    book.note_card(card);
  endtask

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check each transaction, random stalls and one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        book.check_verdict(out_if.card_class, out_if.digit_count, out_if.checksum_ok);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 book.pending_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [BIN_W-1:0] directed_cards[$];
    logic [BIN_W-1:0] card;
    quiet_cycles      = 0;
    hold_request      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_ni            = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.card_number <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes and length boundaries
    directed_cards.push_back('0);
    directed_cards.push_back(BIN_W'(1));
    directed_cards.push_back({BIN_W{1'b1}});
    directed_cards.push_back(BIN_W'(TEN_POW_16 - 64'd1));
    directed_cards.push_back(BIN_W'(TEN_POW_16));
    directed_cards.push_back(BIN_W'(64'd999999999999));
    directed_cards.push_back(BIN_W'(64'd1000000000000));
    // each class on a valid checksum
    directed_cards.push_back(build_card(15, 34, 2, 1'b1));
    directed_cards.push_back(build_card(15, 37, 2, 1'b1));
    directed_cards.push_back(build_card(13, 4, 1, 1'b1));
    directed_cards.push_back(build_card(14, 4, 1, 1'b1));
    directed_cards.push_back(build_card(15, 4, 1, 1'b1));
    directed_cards.push_back(build_card(16, 4, 1, 1'b1));
    directed_cards.push_back(build_card(16, 51, 2, 1'b1));
    directed_cards.push_back(build_card(16, 55, 2, 1'b1));
    // prefixes with no class or at the wrong length
    directed_cards.push_back(build_card(15, 35, 2, 1'b1));
    directed_cards.push_back(build_card(16, 34, 2, 1'b1));
    directed_cards.push_back(build_card(16, 50, 2, 1'b1));
    directed_cards.push_back(build_card(16, 56, 2, 1'b1));
    directed_cards.push_back(build_card(15, 51, 2, 1'b1));
    directed_cards.push_back(build_card(12, 4, 1, 1'b1));
    // known prefix with a failed checksum
    directed_cards.push_back(spoil_check_digit(build_card(15, 37, 2, 1'b1)));
    directed_cards.push_back(spoil_check_digit(build_card(16, 4, 1, 1'b1)));
    directed_cards.push_back(spoil_check_digit(build_card(16, 53, 2, 1'b1)));
    // seventeen digits whose low sixteen pass the luhn test
    directed_cards.push_back(BIN_W'(TEN_POW_16 + 64'(build_card(16, 4, 1, 1'b1))));
    foreach (directed_cards[k]) begin
      send_card(directed_cards[k]);
    end

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        card = random_card();
        send_card(card);
      end
    end
    in_if.valid <= 1'b0;

    // drain
    while (book.pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d results: invalid %0d, prefix 34/37 %0d, lead 4 %0d, prefix 51-55 %0d",
             book.checked, book.class_hits[0], book.class_hits[1], book.class_hits[2],
             book.class_hits[3]);
    $display({"%0d of 18 digit counts seen, %0d mismatches, ",
              "idling on both sides and a %0d-cycle hold-off"},
             $countones(book.counts_seen), book.mismatches, HOLD_CYCLES);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
